@@ hw/rtl/bfz_pkg.sv @@
// shared types and constants of the 3x3 zero-padded box filter
package bfz_pkg;

    // sample and sum formats
    localparam int SAMPLE_BITS = 16;
    localparam int RADIUS      = 3;
    localparam int AREA        = RADIUS * RADIUS;
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(AREA);

    // reciprocal of the area for the constant divide
    localparam int RECIP_SHIFT = SUM_BITS + 4;
    localparam logic [RECIP_SHIFT-4:0] RECIP_MULT =
        (RECIP_SHIFT-3)'((64'd1 << RECIP_SHIFT) / AREA);

    // configuration port
    localparam int CFG_IDX_BITS    = 1;
    localparam int CFG_WIDTH_BITS  = 7;
    localparam int CFG_HEIGHT_BITS = 11;
    localparam int CFG_DATA_BITS   = 11;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    // request opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_BITS-1:0]    t_sum;

    typedef struct packed {
        logic    opcode;
        t_sample sample;
    } t_in_req;

    typedef struct packed {
        t_sample mean_value;
        logic    frame_last;
    } t_out_res;

    // window sum handed to the divider
    typedef struct packed {
        t_sum sum;
        logic last;
    } t_div_req;

endpackage

@@ hw/rtl/box_filter_3x3_zero_pad_unit.sv @@
// 3x3 zero-padded box filter: row delay lines of cells, window sum and divide
//
//  channel   direction  handshake            payload
//  request   in         i_valid / o_ready    i_req  (opcode, sample)
//  result    out        o_valid / i_ready    o_res  (mean_value, frame_last)
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// one request per cycle while o_ready is high; each sample, or a flush while
// draining, shifts the two row lines once. the request that completes a window
// sends its result through tap capture, nine-way sum, reciprocal multiply and
// correction into o_res. a stalled result holds the four-stage pipeline;
// requests keep flowing while any stage has room. synchronous active-low reset
// clears counters and valid flags; lines are never read before being written.
module box_filter_3x3_zero_pad_unit #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  bfz_pkg::t_in_req                      i_req,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output bfz_pkg::t_out_res                     o_res,
    input  logic                                  i_cfg_we,
    input  logic [bfz_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [bfz_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int WB      = $clog2(MAX_WIDTH + 1);
    localparam int RB      = $clog2(MAX_HEIGHT + 2);
    localparam int LB      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int W_RESET = (64 > MAX_WIDTH) ? MAX_WIDTH : 64;
    localparam int H_RESET = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;
    localparam int SUMB    = bfz_pkg::SUM_BITS;

    logic [WB-1:0]    r_w;
    logic [RB-1:0]    r_h;
    logic [RB-1:0]    r_arr_row;
    logic [WB-1:0]    r_arr_col;
    logic [WB-1:0]    r_flush_cnt;
    logic [RB-1:0]    r_pos_row;
    logic [WB-1:0]    r_pos_col;

    logic [bfz_pkg::CFG_WIDTH_BITS-1:0]  cfg_w_raw;
    logic [bfz_pkg::CFG_HEIGHT_BITS-1:0] cfg_h_raw;
    logic [WB-1:0]    n_w;
    logic [RB-1:0]    n_h;

    logic             in_fire;
    logic             draining;
    logic             is_flush_op;
    logic             push;
    logic             primed;
    logic             has_res;
    logic             last;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    bfz_pkg::t_sample push_val;

    bfz_pkg::t_sample r_a0;
    bfz_pkg::t_sample r_a1;
    bfz_pkg::t_sample r_b1;
    bfz_pkg::t_sample r_c1;
    bfz_pkg::t_sample l1_q [MAX_WIDTH];
    bfz_pkg::t_sample l2_q [MAX_WIDTH];
    bfz_pkg::t_sample l1_tail_next;
    bfz_pkg::t_sample l2_tail_next;
    logic [LB-1:0]    entry_idx;

    bfz_pkg::t_sample taps [9];
    logic             r_s1_valid;
    bfz_pkg::t_sample r_s1_tap [9];
    logic             r_s1_last;
    logic             s2_ready;

    logic             r_s2_valid;
    bfz_pkg::t_div_req r_s2_req;
    logic             div_ready;
    logic [SUMB-1:0]  win_sum;

    // clamp configuration values to the supported range
    assign cfg_w_raw = i_cfg_data[bfz_pkg::CFG_WIDTH_BITS-1:0];
    assign cfg_h_raw = i_cfg_data[bfz_pkg::CFG_HEIGHT_BITS-1:0];

    always_comb begin
        if (cfg_w_raw == '0) begin
            n_w = WB'(1);
        end else if (32'(cfg_w_raw) > MAX_WIDTH) begin
            n_w = WB'(MAX_WIDTH);
        end else begin
            n_w = WB'(cfg_w_raw);
        end
        if (cfg_h_raw == '0) begin
            n_h = RB'(1);
        end else if (32'(cfg_h_raw) > MAX_HEIGHT) begin
            n_h = RB'(MAX_HEIGHT);
        end else begin
            n_h = RB'(cfg_h_raw);
        end
    end

    // request decode
    assign in_fire     = i_valid && o_ready;
    assign draining    = r_arr_row >= r_h;
    assign is_flush_op = i_req.opcode == bfz_pkg::OP_FLUSH;
    assign push        = in_fire && (draining || !is_flush_op);
    assign push_val    = draining ? '0 : i_req.sample;

    // a result exists once one row plus one pixel has arrived
    assign primed = draining ?
        ((r_h >= RB'(2)) || (r_flush_cnt != '0)) :
        ((r_arr_row >= RB'(2)) || ((r_arr_row == RB'(1)) && (r_arr_col != '0)));
    assign has_res = push && primed;
    assign last    = (r_pos_row == r_h - RB'(1)) && (r_pos_col == r_w - WB'(1));

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w         <= WB'(W_RESET);
            r_h         <= RB'(H_RESET);
            r_arr_row   <= '0;
            r_arr_col   <= '0;
            r_flush_cnt <= '0;
            r_pos_row   <= '0;
            r_pos_col   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bfz_pkg::REG_FRAME_WIDTH) begin
                r_w <= n_w;
            end
            if (i_cfg_idx == bfz_pkg::REG_FRAME_HEIGHT) begin
                r_h <= n_h;
            end
            r_arr_row   <= '0;
            r_arr_col   <= '0;
            r_flush_cnt <= '0;
            r_pos_row   <= '0;
            r_pos_col   <= '0;
        end else if (push) begin
            if (has_res && last) begin
                r_arr_row   <= '0;
                r_arr_col   <= '0;
                r_flush_cnt <= '0;
                r_pos_row   <= '0;
                r_pos_col   <= '0;
            end else begin
                if (draining) begin
                    r_flush_cnt <= r_flush_cnt + WB'(1);
                end else if (r_arr_col + WB'(1) == r_w) begin
                    r_arr_col <= '0;
                    r_arr_row <= r_arr_row + RB'(1);
                end else begin
                    r_arr_col <= r_arr_col + WB'(1);
                end
                if (has_res) begin
                    if (r_pos_col + WB'(1) == r_w) begin
                        r_pos_col <= '0;
                        r_pos_row <= r_pos_row + RB'(1);
                    end else begin
                        r_pos_col <= r_pos_col + WB'(1);
                    end
                end
            end
        end
    end

    // newest-row taps and the short delays behind each line
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_a0 <= push_val;
            r_a1 <= r_a0;
            r_b1 <= l1_q[MAX_WIDTH-1];
            r_c1 <= l2_q[MAX_WIDTH-1];
        end
    end

    // row lines: data enters w cells before the tail
    assign entry_idx = LB'(MAX_WIDTH - 32'(r_w));

    for (genvar j = 0; j < MAX_WIDTH; j++) begin : g_line
        bfz_pkg::t_sample l1_prev;
        bfz_pkg::t_sample l2_prev;
        bfz_pkg::t_sample l1_next;
        bfz_pkg::t_sample l2_next;

        if (j == 0) begin : g_head
            assign l1_prev = r_a0;
            assign l2_prev = l1_q[MAX_WIDTH-1];
        end else begin : g_body
            assign l1_prev = l1_q[j-1];
            assign l2_prev = l2_q[j-1];
        end

        bfz_cell u_l1_cell (
            .i_clk   (i_clk),
            .i_en    (push),
            .i_take  (entry_idx == LB'(j)),
            .i_entry (r_a0),
            .i_prev  (l1_prev),
            .o_q     (l1_q[j]),
            .o_next  (l1_next)
        );

        bfz_cell u_l2_cell (
            .i_clk   (i_clk),
            .i_en    (push),
            .i_take  (entry_idx == LB'(j)),
            .i_entry (l1_q[MAX_WIDTH-1]),
            .i_prev  (l2_prev),
            .o_q     (l2_q[j]),
            .o_next  (l2_next)
        );

        if (j == MAX_WIDTH - 1) begin : g_tail
            assign l1_tail_next = l1_next;
            assign l2_tail_next = l2_next;
        end
    end

    // window taps after this shift, zero outside the frame
    assign top_ok   = r_pos_row != '0;
    assign bot_ok   = r_pos_row != r_h - RB'(1);
    assign left_ok  = r_pos_col != '0;
    assign right_ok = r_pos_col != r_w - WB'(1);

    assign taps[0] = (top_ok && left_ok)  ? r_c1              : '0;
    assign taps[1] = top_ok               ? l2_q[MAX_WIDTH-1] : '0;
    assign taps[2] = (top_ok && right_ok) ? l2_tail_next      : '0;
    assign taps[3] = left_ok              ? r_b1              : '0;
    assign taps[4] = l1_q[MAX_WIDTH-1];
    assign taps[5] = right_ok             ? l1_tail_next      : '0;
    assign taps[6] = (bot_ok && left_ok)  ? r_a1              : '0;
    assign taps[7] = bot_ok               ? r_a0              : '0;
    assign taps[8] = (bot_ok && right_ok) ? push_val          : '0;

    // tap capture stage
    assign s2_ready = !r_s2_valid || div_ready;
    assign o_ready  = !r_s1_valid || s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (has_res) begin
            r_s1_valid <= 1'b1;
        end else if (s2_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (has_res) begin
            r_s1_tap  <= taps;
            r_s1_last <= last;
        end
    end

    // nine-way sum stage
    always_comb begin
        win_sum = '0;
        for (int k = 0; k < 9; k++) begin
            win_sum = win_sum + SUMB'(r_s1_tap[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_req.sum  <= win_sum;
            r_s2_req.last <= r_s1_last;
        end
    end

    bfz_div9 u_div9 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .o_ready (div_ready),
        .i_req   (r_s2_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_flush_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !draining && is_flush_op && !i_cfg_we
        |=> $stable(r_arr_row) && $stable(r_arr_col) && $stable(r_flush_cnt))
        else $error("early flush request moved the frame counters");
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        has_res && last |=> r_arr_row == '0 && r_arr_col == '0 && r_pos_row == '0)
        else $error("counters did not restart after the last result");
    a_drain_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        draining |-> r_arr_col == '0 && r_flush_cnt <= r_w)
        else $error("drain window counters out of step");
`endif

endmodule

@@ hw/rtl/bfz_cell.sv @@
// one sample cell of a row delay line
module bfz_cell (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_take,
    input  bfz_pkg::t_sample  i_entry,
    input  bfz_pkg::t_sample  i_prev,
    output bfz_pkg::t_sample  o_q,
    output bfz_pkg::t_sample  o_next
);

    bfz_pkg::t_sample r_q;
    bfz_pkg::t_sample n_q;

    // entry point of the line or shift from the neighbour
    assign n_q = i_take ? i_entry : i_prev;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q    = r_q;
    assign o_next = n_q;

endmodule

@@ hw/rtl/bfz_div9.sv @@
// two-stage truncating divide of the window sum by the area
module bfz_div9 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bfz_pkg::t_div_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output bfz_pkg::t_out_res o_res
);

    localparam int SB = bfz_pkg::SUM_BITS;
    localparam int KS = bfz_pkg::RECIP_SHIFT;
    localparam int PW = SB + KS - 3;
    localparam int QB = SB - 3;

    logic            r_s3_valid;
    logic [SB-1:0]   r_mag;
    logic [QB-1:0]   r_q0;
    logic            r_neg;
    logic            r_last;
    logic            s3_ready;
    logic            out_ready;
    logic [SB-1:0]   mag;
    logic [PW-1:0]   prod;
    logic [SB-1:0]   nine_q;
    logic [SB-1:0]   rem;
    logic [QB-1:0]   quot;
    logic [QB-1:0]   signed_quot;

    assign out_ready = !o_valid || i_ready;
    assign s3_ready  = !r_s3_valid || out_ready;
    assign o_ready   = s3_ready;

    // magnitude times reciprocal, estimate may be one low
    assign mag  = i_req.sum[SB-1] ? SB'(-i_req.sum) : SB'(i_req.sum);
    assign prod = PW'(mag) * PW'(bfz_pkg::RECIP_MULT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (s3_ready) begin
            r_s3_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_ready && i_valid) begin
            r_mag  <= mag;
            r_q0   <= prod[PW-1:KS];
            r_neg  <= i_req.sum[SB-1];
            r_last <= i_req.last;
        end
    end

    // correction step and sign
    assign nine_q      = (SB'(r_q0) << 3) + SB'(r_q0);
    assign rem         = r_mag - nine_q;
    assign quot        = (rem >= SB'(bfz_pkg::AREA)) ? r_q0 + QB'(1) : r_q0;
    assign signed_quot = r_neg ? -quot : quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_ready) begin
            o_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s3_valid) begin
            o_res.mean_value <= signed_quot[bfz_pkg::SAMPLE_BITS-1:0];
            o_res.frame_last <= r_last;
        end
    end

`ifndef SYNTHESIS
    a_s3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid && !out_ready |=> r_s3_valid && $stable(r_q0))
        else $error("divider stage lost a held request");
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> rem < SB'(2 * bfz_pkg::AREA))
        else $error("reciprocal estimate off by more than one");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid && o_valid && !i_ready |=> r_s3_valid)
        else $error("divider dropped a request while stalled");
`endif

endmodule
